FILE: hdl/gpp_pkg.sv
// Shared types, register codes and helpers of the GIF pixel placement block.
package gpp_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 32;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ORIGIN      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_INDEX  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT_INDEX = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE        = 4'd7;

    localparam logic [2:0] DISP_UNSPEC     = 3'd0;
    localparam logic [2:0] DISP_NONE       = 3'd1;
    localparam logic [2:0] DISP_BACKGROUND = 3'd2;
    localparam logic [2:0] DISP_PREVIOUS   = 3'd3;

    localparam int FM_INTERLACE = 3;
    localparam int FM_FIRST     = 4;

    localparam logic [8:0] TRANSP_OFF = 9'h1FF;

    // Interlace pass boundaries: pass n ends at (h + ROUND) >> SHIFT.
    localparam logic [3:0] PASS1_ROUND = 4'd7;
    localparam logic [3:0] PASS2_ROUND = 4'd3;
    localparam logic [3:0] PASS3_ROUND = 4'd1;

    typedef struct packed {
        logic [7:0] pix_code;
        logic       frame_start;
    } t_item;

    typedef struct packed {
        logic        write_enable;
        logic [31:0] pixel_address;
        logic [7:0]  pixel_value;
        logic        out_of_bounds;
    } t_result;

    typedef struct packed {
        logic [15:0]       canvas_width;
        logic [15:0]       canvas_height;
        logic [15:0]       image_left;
        logic [15:0]       image_top;
        logic [15:0]       image_width;
        logic [15:0]       image_height;
        logic [7:0]        background_index;
        logic signed [8:0] key_index;
        logic [4:0]        frame_mode;
        logic [15:0]       p1_rows;
        logic [15:0]       p2_rows;
        logic [15:0]       p3_rows;
    } t_cfg;

    // Classified pixel handed from the front end to the address stage.
    typedef struct packed {
        logic        write_enable;
        logic        out_of_bounds;
        logic [7:0]  pixel_value;
        logic [15:0] row;
        logic [15:0] col;
    } t_mid;

    function automatic logic [15:0] pass_end(input logic [15:0] h, input logic [3:0] round,
                                             input logic [1:0] sh);
        logic [16:0] sum;
        sum = 17'(h) + 17'(round);
        return 16'(sum >> sh);
    endfunction

endpackage

FILE: hdl/gpp_fifo.sv
// Small register FIFO with the head word shown combinationally.
module gpp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = gpp_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             push_ok, pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push_ok) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop_ok) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({push_ok, pop_ok})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fifo count above depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into a full fifo");
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_full && o_empty))
        else $error("fifo reports full and empty at once");
`endif

endmodule

FILE: hdl/gpp_front.sv
// Front end: pixel counters, interlace row mapping, bounds check and write rules.
module gpp_front #(
    parameter int COORD_BITS = gpp_pkg::COORD_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gpp_pkg::t_cfg   i_cfg,
    input  logic            i_push,
    input  gpp_pkg::t_item  i_item,
    output logic            o_full,
    output logic            o_push,
    output gpp_pkg::t_mid   o_mid,
    input  logic            i_mid_full
);
    import gpp_pkg::*;

    localparam int CW1  = COORD_BITS + 1;
    localparam int MAPW = COORD_BITS + 3;
    localparam int ROWW = ((MAPW > 16) ? MAPW : 16) + 1;

    logic [COORD_BITS-1:0] r_col, n_col;
    logic [COORD_BITS-1:0] r_row, n_row;
    logic                  r_a_valid, n_a_valid;
    logic [7:0]            r_a_color;
    logic [COORD_BITS-1:0] r_a_col;
    logic [COORD_BITS-1:0] r_a_row;

    logic                  accept;
    logic [COORD_BITS-1:0] col_use, row_use;
    logic [CW1-1:0]        col_inc;
    logic                  wrap;

    logic [15:0]           r16;
    logic [MAPW-1:0]       mapped;
    logic [ROWW-1:0]       row_full;
    logic [16:0]           col_full;
    logic                  oob, transp, first, we;
    logic [7:0]            val;

    assign o_full    = r_a_valid && i_mid_full;
    assign accept    = i_push && !o_full;
    assign o_push    = r_a_valid && !i_mid_full;
    assign n_a_valid = accept || (r_a_valid && i_mid_full);

    // Counter update for the accepted pixel.
    always_comb begin
        col_use = i_item.frame_start ? '0 : r_col;
        row_use = i_item.frame_start ? '0 : r_row;
        col_inc = CW1'(col_use) + CW1'(1);
        wrap    = 17'(col_inc) >= 17'(i_cfg.image_width);
        n_col   = wrap ? '0 : col_inc[COORD_BITS-1:0];
        n_row   = wrap ? row_use + COORD_BITS'(1) : row_use;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_color <= i_item.pix_code;
            r_a_col   <= col_use;
            r_a_row   <= row_use;
        end
    end

    // Classification of the held pixel.
    always_comb begin
        r16 = 16'(r_a_row);
        if (!i_cfg.frame_mode[FM_INTERLACE]) begin
            mapped = MAPW'(r_a_row);
        end else if (r16 < i_cfg.p1_rows) begin
            mapped = MAPW'(r_a_row) << 3;
        end else if (r16 < i_cfg.p2_rows) begin
            mapped = (MAPW'(r16 - i_cfg.p1_rows) << 3) + MAPW'(4);
        end else if (r16 < i_cfg.p3_rows) begin
            mapped = (MAPW'(r16 - i_cfg.p2_rows) << 2) + MAPW'(2);
        end else begin
            mapped = (MAPW'(r16 - i_cfg.p3_rows) << 1) + MAPW'(1);
        end

        row_full = ROWW'(i_cfg.image_top) + ROWW'(mapped);
        col_full = 17'(i_cfg.image_left) + 17'(r_a_col);
        oob      = (row_full >= ROWW'(i_cfg.canvas_height)) ||
                   (col_full >= 17'(i_cfg.canvas_width));
        transp   = !i_cfg.key_index[8] &&
                   (r_a_color == i_cfg.key_index[7:0]);
        first    = i_cfg.frame_mode[FM_FIRST];

        we  = 1'b0;
        val = '0;
        case (i_cfg.frame_mode[2:0])
            DISP_UNSPEC, DISP_NONE: begin
                if (!transp) begin
                    we  = 1'b1;
                    val = r_a_color;
                end else if (first) begin
                    we  = 1'b1;
                    val = i_cfg.background_index;
                end
            end
            DISP_BACKGROUND: begin
                we  = 1'b1;
                val = transp ? i_cfg.background_index : r_a_color;
            end
            DISP_PREVIOUS: begin
                if (first) begin
                    we  = 1'b1;
                    val = transp ? i_cfg.background_index : r_a_color;
                end else if (!transp) begin
                    we  = 1'b1;
                    val = r_a_color;
                end
            end
            default: begin
                we  = 1'b0;
                val = '0;
            end
        endcase
        if (oob) begin
            we  = 1'b0;
            val = '0;
        end

        o_mid.write_enable  = we;
        o_mid.out_of_bounds = oob;
        o_mid.pixel_value   = val;
        o_mid.row           = we ? row_full[15:0] : '0;
        o_mid.col           = we ? col_full[15:0] : '0;
    end

endmodule

FILE: hdl/gpp_back.sv
// Back end: frame-store address as row times canvas width plus column.
module gpp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_canvas_width,
    input  logic              i_mid_valid,
    output logic              o_mid_pop,
    input  gpp_pkg::t_mid     i_mid,
    input  logic              i_out_full,
    output logic              o_out_push,
    output gpp_pkg::t_result  o_result
);
    import gpp_pkg::*;

    logic        r_valid, n_valid;
    logic [31:0] r_prod;
    logic [15:0] r_col;
    logic        r_we;
    logic        r_oob;
    logic [7:0]  r_val;
    logic        advance;

    assign o_out_push = r_valid && !i_out_full;
    assign advance    = !r_valid || !i_out_full;
    assign o_mid_pop  = i_mid_valid && advance;
    assign n_valid    = o_mid_pop || (r_valid && i_out_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_mid_pop) begin
            r_prod <= 32'(i_mid.row) * 32'(i_canvas_width);
            r_col  <= i_mid.col;
            r_we   <= i_mid.write_enable;
            r_oob  <= i_mid.out_of_bounds;
            r_val  <= i_mid.pixel_value;
        end
    end

    // Rows and columns are zero for items without a write, so the sum is zero too.
    always_comb begin
        o_result.write_enable  = r_we;
        o_result.pixel_address = r_prod + 32'(r_col);
        o_result.pixel_value   = r_val;
        o_result.out_of_bounds = r_oob;
    end

endmodule

FILE: hdl/gif_pixel_placement_top.sv
// Top level of the GIF pixel placement block: registers, queues, front and back end.
// Path: front stage register, classified-pixel queue, back-end register, result queue.
// Throughput: one item per cycle while full is low, one counter update per accepted item.
// Full rises only when the classified-pixel queue is full and the front stage holds an item.
// Synchronous active-low reset clears counters, queues, valid bits and config registers at once.
// There is no clearing pass: the block accepts items in the first cycle after reset.
module gif_pixel_placement_top #(
    parameter int COORD_BITS = gpp_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  gpp_pkg::t_item                   i_item,
    output logic                             empty,
    input  logic                             pop,
    output gpp_pkg::t_result                 o_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gpp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gpp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gpp_pkg::*;

    t_cfg    r_cfg;
    logic    cfg_write;

    logic    mid_push, mid_full, mid_pop, mid_empty;
    t_mid    mid_in, mid_out;
    logic    out_push, out_full;
    t_result back_result;

    // Configuration writes are always taken. The interlace pass limits are
    // derived from the image height when it is written, so a pixel that
    // arrives right after the write already sees them.
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.canvas_width     <= '0;
            r_cfg.canvas_height    <= '0;
            r_cfg.image_left       <= '0;
            r_cfg.image_top        <= '0;
            r_cfg.image_width      <= '0;
            r_cfg.image_height     <= '0;
            r_cfg.background_index <= '0;
            r_cfg.key_index        <= TRANSP_OFF;
            r_cfg.frame_mode       <= '0;
            r_cfg.p1_rows          <= '0;
            r_cfg.p2_rows          <= '0;
            r_cfg.p3_rows          <= '0;
        end else if (cfg_write) begin
            case (i_cfg_index)
                REG_CANVAS_WIDTH:      r_cfg.canvas_width      <= i_cfg_data[15:0];
                REG_CANVAS_HEIGHT:     r_cfg.canvas_height     <= i_cfg_data[15:0];
                REG_IMAGE_ORIGIN: begin
                    r_cfg.image_left <= i_cfg_data[15:0];
                    r_cfg.image_top  <= i_cfg_data[31:16];
                end
                REG_IMAGE_WIDTH:       r_cfg.image_width       <= i_cfg_data[15:0];
                REG_IMAGE_HEIGHT: begin
                    r_cfg.image_height <= i_cfg_data[15:0];
                    r_cfg.p1_rows      <= pass_end(i_cfg_data[15:0], PASS1_ROUND, 2'd3);
                    r_cfg.p2_rows      <= pass_end(i_cfg_data[15:0], PASS2_ROUND, 2'd2);
                    r_cfg.p3_rows      <= pass_end(i_cfg_data[15:0], PASS3_ROUND, 2'd1);
                end
                REG_BACKGROUND_INDEX:  r_cfg.background_index  <= i_cfg_data[7:0];
                REG_TRANSPARENT_INDEX: r_cfg.key_index         <= i_cfg_data[8:0];
                REG_FRAME_MODE:        r_cfg.frame_mode        <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // The front end counts and classifies each item in stream order.
    gpp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_push     (mid_push),
        .o_mid      (mid_in),
        .i_mid_full (mid_full)
    );

    // Short queue that decouples classification from the address multiply.
    gpp_fifo #(
        .WIDTH ($bits(t_mid)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_in),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_out),
        .o_empty (mid_empty)
    );

    // The back end forms the frame-store address with one registered multiply.
    gpp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_canvas_width (r_cfg.canvas_width),
        .i_mid_valid    (!mid_empty),
        .o_mid_pop      (mid_pop),
        .i_mid          (mid_out),
        .i_out_full     (out_full),
        .o_out_push     (out_push),
        .o_result       (back_result)
    );

    // Result queue: the oldest result sits on the output ports while empty is low.
    gpp_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (back_result),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

`ifndef SYNTHESIS
    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.write_enable) |->
            (o_result.pixel_address == '0) && (o_result.pixel_value == '0))
        else $error("result without a write carries nonzero fields");
    a_oob_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.out_of_bounds) |-> !o_result.write_enable)
        else $error("off-canvas pixel issued a write");
    a_full_needs_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> mid_full)
        else $error("input stalled while the classified-pixel queue has room");
`endif

endmodule
